@@ hw/rtl/kic_pkg.sv @@
// Shared types, key codes and constants of the keypad integer calculator.
// Used by the controller, the datapath and the top level; depends on nothing.
package kic_pkg;

	localparam int MAX_DIGITS  = 16;
	localparam int BCD_DIGITS  = 20;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int RADIX       = 10;
	localparam int PCT_DIVISOR = 100;
	localparam int WORD_STEPS  = 64;

	localparam logic [7:0] KEY_BACKSPACE  = 8'h08;
	localparam logic [7:0] KEY_ENTER      = 8'h0A;
	localparam logic [7:0] KEY_PERCENT    = 8'h25;
	localparam logic [7:0] KEY_STAR       = 8'h2A;
	localparam logic [7:0] KEY_PLUS       = 8'h2B;
	localparam logic [7:0] KEY_MINUS      = 8'h2D;
	localparam logic [7:0] KEY_SLASH      = 8'h2F;
	localparam logic [7:0] KEY_ZERO       = 8'h30;
	localparam logic [7:0] KEY_NINE       = 8'h39;
	localparam logic [7:0] KEY_EQUALS     = 8'h3D;
	localparam logic [7:0] KEY_UC_A       = 8'h41;
	localparam logic [7:0] KEY_UC_B       = 8'h42;
	localparam logic [7:0] KEY_UC_C       = 8'h43;
	localparam logic [7:0] KEY_UC_L       = 8'h4C;
	localparam logic [7:0] KEY_UC_M       = 8'h4D;
	localparam logic [7:0] KEY_UC_N       = 8'h4E;
	localparam logic [7:0] KEY_UC_S       = 8'h53;
	localparam logic [7:0] KEY_UNDERSCORE = 8'h5F;
	localparam logic [7:0] KEY_LC_A       = 8'h61;
	localparam logic [7:0] KEY_LC_B       = 8'h62;
	localparam logic [7:0] KEY_LC_C       = 8'h63;
	localparam logic [7:0] KEY_LC_L       = 8'h6C;
	localparam logic [7:0] KEY_LC_M       = 8'h6D;
	localparam logic [7:0] KEY_LC_N       = 8'h6E;
	localparam logic [7:0] KEY_LC_S       = 8'h73;

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

	typedef enum logic [3:0] {
		KC_NONE, KC_DIGIT, KC_OP, KC_EQ, KC_CLR, KC_PCT, KC_NEG, KC_BS,
		KC_MR, KC_MS, KC_MC, KC_MA, KC_MB
	} key_class_t;

	typedef enum logic [4:0] {
		CMD_NOP, CMD_DIGIT, CMD_CLEAR, CMD_MEM_CLEAR, CMD_BACKSPACE,
		CMD_PARSE_INIT, CMD_PARSE_STEP, CMD_PARSE_FIX,
		CMD_SET_R_X, CMD_ALU, CMD_COMMIT, CMD_NEG_X, CMD_LOAD_MEM,
		CMD_MUL_INIT, CMD_MUL_STEP, CMD_DIV_INIT, CMD_DIV_STEP, CMD_DIV_FIX, CMD_DIV_ERR,
		CMD_SHOW_INIT, CMD_SHOW_STEP, CMD_SHOW_DONE,
		CMD_OP_KEY, CMD_EQ_END, CMD_PCT_END, CMD_MR_END,
		CMD_MEM_STORE, CMD_MEM_ADD, CMD_MEM_SUB
	} cmd_t;

	typedef enum logic [1:0] {DS_TOTAL_BY_X, DS_X_BY_PCT, DS_R_BY_PCT} div_src_t;

	typedef struct packed {
		cmd_t       code;
		logic [3:0] digit;
		op_t        op;
		div_src_t   src;
	} dp_cmd_t;

	typedef struct packed {
		logic step_last;
		logic parse_last;
		logic x_zero;
		logic pend;
		op_t  op;
		logic err;
		logic memv;
	} dp_status_t;

	typedef struct packed {
		logic [7:0] key_code;
	} key_item_t;

	typedef struct packed {
		logic        key_accepted;
		logic [63:0] shown_digits;
		logic [4:0]  shown_length;
		logic        shown_negative;
		logic        error_shown;
		logic        memory_indicator;
	} display_item_t;

	function automatic key_class_t classify(input logic [7:0] k);
		key_class_t c;
		unique case (k) inside
			KEY_UC_C, KEY_LC_C:                       c = KC_CLR;
			KEY_UC_L, KEY_LC_L:                       c = KC_MC;
			[KEY_ZERO:KEY_NINE]:                      c = KC_DIGIT;
			KEY_PLUS, KEY_MINUS, KEY_STAR, KEY_SLASH: c = KC_OP;
			KEY_EQUALS, KEY_ENTER:                    c = KC_EQ;
			KEY_PERCENT:                              c = KC_PCT;
			KEY_UC_N, KEY_LC_N, KEY_UNDERSCORE:       c = KC_NEG;
			KEY_BACKSPACE:                            c = KC_BS;
			KEY_UC_M, KEY_LC_M:                       c = KC_MR;
			KEY_UC_S, KEY_LC_S:                       c = KC_MS;
			KEY_UC_A, KEY_LC_A:                       c = KC_MA;
			KEY_UC_B, KEY_LC_B:                       c = KC_MB;
			default:                                  c = KC_NONE;
		endcase
		return c;
	endfunction

	function automatic op_t key_op(input logic [7:0] k);
		op_t o;
		unique case (k)
			KEY_MINUS: o = OP_SUB;
			KEY_STAR:  o = OP_MUL;
			KEY_SLASH: o = OP_DIV;
			default:   o = OP_ADD;
		endcase
		return o;
	endfunction

endpackage

@@ hw/rtl/kic_stream_if.sv @@
// Valid/ready channel carrying one word of a given payload type.
// Stands alone; the payload types come from kic_pkg at the instance.
interface kic_stream_if #(parameter type payload_t = logic [7:0]) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/kic_ctrl.sv @@
// Controller of the keypad calculator: decodes a key and sequences the datapath.
// Depends on kic_pkg for key classes, commands and status.
module kic_ctrl
	import kic_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] key_code,
	output logic       in_ready,
	input  logic       out_busy,
	output logic       out_load,
	output logic       key_accepted,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_PARSE, S_PARSE_FIX, S_ROUTE, S_MUL, S_PCT_DIV,
		S_DIV, S_DIV_FIX, S_COMMIT, S_SHOW_INIT, S_SHOW, S_SHOW_END, S_TAIL, S_FINISH
	} state_t;

	state_t     state_q, state_d;
	key_class_t cls_q;
	logic [3:0] digit_q;
	op_t        kop_q;

	assign in_ready     = (state_q == S_IDLE);
	assign out_load     = (state_q == S_FINISH) && !out_busy;
	assign key_accepted = (cls_q != KC_NONE);

	always_comb begin
		state_d   = state_q;
		cmd.code  = CMD_NOP;
		cmd.digit = digit_q;
		cmd.op    = kop_q;
		cmd.src   = DS_TOTAL_BY_X;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				if (cls_q == KC_CLR) begin
					cmd.code = CMD_CLEAR;
				end else if (cls_q == KC_MC) begin
					cmd.code = CMD_MEM_CLEAR;
				end else if (cls_q == KC_NONE || status.err) begin
					cmd.code = CMD_NOP;
				end else if (cls_q == KC_DIGIT) begin
					cmd.code = CMD_DIGIT;
				end else if (cls_q == KC_BS) begin
					cmd.code = CMD_BACKSPACE;
				end else if (cls_q == KC_MR) begin
					if (status.memv) begin
						cmd.code = CMD_LOAD_MEM;
						state_d  = S_SHOW_INIT;
					end
				end else begin
					cmd.code = CMD_PARSE_INIT;
					state_d  = S_PARSE;
				end
			end
			S_PARSE: begin
				cmd.code = CMD_PARSE_STEP;
				if (status.parse_last)
					state_d = S_PARSE_FIX;
			end
			S_PARSE_FIX: begin
				cmd.code = CMD_PARSE_FIX;
				state_d  = S_ROUTE;
			end
			S_ROUTE: begin
				state_d = S_FINISH;
				case (cls_q)
					KC_MS: cmd.code = CMD_MEM_STORE;
					KC_MA: cmd.code = CMD_MEM_ADD;
					KC_MB: cmd.code = CMD_MEM_SUB;
					KC_NEG: begin
						if (!status.x_zero) begin
							cmd.code = CMD_NEG_X;
							state_d  = S_SHOW_INIT;
						end
					end
					KC_PCT: begin
						if (status.pend) begin
							cmd.code = CMD_MUL_INIT;
							state_d  = S_MUL;
						end else begin
							cmd.code = CMD_DIV_INIT;
							cmd.src  = DS_X_BY_PCT;
							state_d  = S_DIV;
						end
					end
					default: begin
						// Operator and equals keys settle the pending operation.
						if (!status.pend) begin
							cmd.code = CMD_SET_R_X;
							state_d  = S_COMMIT;
						end else if (status.op == OP_ADD || status.op == OP_SUB) begin
							cmd.code = CMD_ALU;
							state_d  = S_COMMIT;
						end else if (status.op == OP_MUL) begin
							cmd.code = CMD_MUL_INIT;
							state_d  = S_MUL;
						end else if (status.x_zero) begin
							cmd.code = CMD_DIV_ERR;
							state_d  = S_TAIL;
						end else begin
							cmd.code = CMD_DIV_INIT;
							cmd.src  = DS_TOTAL_BY_X;
							state_d  = S_DIV;
						end
					end
				endcase
			end
			S_MUL: begin
				cmd.code = CMD_MUL_STEP;
				if (status.step_last)
					state_d = (cls_q == KC_PCT) ? S_PCT_DIV : S_COMMIT;
			end
			S_PCT_DIV: begin
				cmd.code = CMD_DIV_INIT;
				cmd.src  = DS_R_BY_PCT;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.code = CMD_DIV_STEP;
				if (status.step_last)
					state_d = S_DIV_FIX;
			end
			S_DIV_FIX: begin
				cmd.code = CMD_DIV_FIX;
				state_d  = (cls_q == KC_PCT) ? S_SHOW_INIT : S_COMMIT;
			end
			S_COMMIT: begin
				cmd.code = CMD_COMMIT;
				state_d  = S_SHOW_INIT;
			end
			S_SHOW_INIT: begin
				cmd.code = CMD_SHOW_INIT;
				state_d  = S_SHOW;
			end
			S_SHOW: begin
				cmd.code = CMD_SHOW_STEP;
				if (status.step_last)
					state_d = S_SHOW_END;
			end
			S_SHOW_END: begin
				cmd.code = CMD_SHOW_DONE;
				state_d  = S_TAIL;
			end
			S_TAIL: begin
				state_d = S_FINISH;
				case (cls_q)
					KC_OP:   cmd.code = CMD_OP_KEY;
					KC_EQ:   cmd.code = CMD_EQ_END;
					KC_PCT:  cmd.code = CMD_PCT_END;
					KC_MR:   cmd.code = CMD_MR_END;
					default: cmd.code = CMD_NOP;
				endcase
			end
			S_FINISH: begin
				if (!out_busy)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cls_q   <= KC_NONE;
			digit_q <= 4'd0;
			kop_q   <= OP_ADD;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid) begin
				cls_q   <= classify(key_code);
				digit_q <= key_code[3:0];
				kop_q   <= key_op(key_code);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> state_q == S_IDLE)
		else $error("controller did not return to idle after delivering a word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> state_q == S_DISPATCH)
		else $error("accepted key was not dispatched");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_busy) |=> state_q == S_FINISH)
		else $error("result word left the finish state while the receiver stalled");

endmodule

@@ hw/rtl/kic_dp.sv @@
// Datapath of the keypad calculator: entry, total, memory and the iterative
// parse, multiply, divide and binary-to-BCD units. Depends on kic_pkg.
module kic_dp
	import kic_pkg::*;
#(
	parameter int DISPLAY_CHARS = 16
)
(
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	output dp_status_t    status,
	output display_item_t view
);

	localparam logic [5:0] DCHARS = 6'(DISPLAY_CHARS);

	// Calculator state.
	logic [63:0] ent_q;
	logic [4:0]  len_q;
	logic        neg_q;
	logic [63:0] total_q;
	op_t         op_q;
	logic        pend_q;
	logic        start_q;
	logic        err_q;
	logic [63:0] mem_q;
	logic        memv_q;

	// Working registers of the iterative units.
	logic [63:0]      x_q, y_q, a_q, b_q, r_q;
	logic [64:0]      rem_q;
	logic             qneg_q;
	logic             vneg_q;
	logic [BCD_W-1:0] bcd_q;
	logic [5:0]       cnt_q;

	logic [4:0]       eff_len;
	logic             eff_neg;
	logic [63:0]      eff_ent;
	logic             room;
	logic [BCD_W-1:0] adj;
	logic [4:0]       n_digits;
	logic             too_long;
	logic [63:0]      dvd, dvs;
	logic [64:0]      rem_sh;
	logic             rem_ge;

	always_comb begin
		// The first digit after an operator or equals starts an empty entry.
		eff_len = start_q ? 5'd0 : len_q;
		eff_neg = start_q ? 1'b0 : neg_q;
		eff_ent = start_q ? 64'd0 : ent_q;
		room    = (({1'b0, eff_len} + {5'd0, eff_neg}) < DCHARS)
			&& (eff_len < 5'(MAX_DIGITS));
	end

	always_comb begin
		n_digits = 5'd1;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
			if (bcd_q[4*i +: 4] != 4'd0)
				n_digits = 5'(i + 1);
		end
		too_long = ({1'b0, n_digits} + {5'd0, vneg_q}) > DCHARS;
	end

	always_comb begin
		case (cmd.src)
			DS_X_BY_PCT: begin
				dvd = x_q;
				dvs = 64'(PCT_DIVISOR);
			end
			DS_R_BY_PCT: begin
				dvd = r_q;
				dvs = 64'(PCT_DIVISOR);
			end
			default: begin
				dvd = total_q;
				dvs = x_q;
			end
		endcase
		rem_sh = {rem_q[63:0], a_q[63]};
		rem_ge = rem_sh >= {1'b0, b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q   <= 64'd0;
			len_q   <= 5'd1;
			neg_q   <= 1'b0;
			total_q <= 64'd0;
			op_q    <= OP_ADD;
			pend_q  <= 1'b0;
			start_q <= 1'b1;
			err_q   <= 1'b0;
			mem_q   <= 64'd0;
			memv_q  <= 1'b0;
		end else begin
			case (cmd.code)
				CMD_CLEAR: begin
					ent_q   <= 64'd0;
					len_q   <= 5'd1;
					neg_q   <= 1'b0;
					total_q <= 64'd0;
					op_q    <= OP_ADD;
					pend_q  <= 1'b0;
					start_q <= 1'b1;
					err_q   <= 1'b0;
				end
				CMD_MEM_CLEAR: begin
					mem_q  <= 64'd0;
					memv_q <= 1'b0;
				end
				CMD_DIGIT: begin
					start_q <= 1'b0;
					neg_q   <= eff_neg;
					if (room) begin
						ent_q <= {eff_ent[59:0], cmd.digit};
						len_q <= eff_len + 5'd1;
					end else begin
						ent_q <= eff_ent;
						len_q <= eff_len;
					end
				end
				CMD_BACKSPACE: begin
					if (start_q) begin
						ent_q <= 64'd0;
						len_q <= 5'd0;
						neg_q <= 1'b0;
					end else if (len_q != 5'd0) begin
						ent_q <= ent_q >> 4;
						len_q <= len_q - 5'd1;
						if (len_q == 5'd1)
							neg_q <= 1'b0;
					end
				end
				CMD_COMMIT: begin
					total_q <= r_q;
					pend_q  <= 1'b0;
					op_q    <= OP_ADD;
				end
				CMD_DIV_ERR: begin
					err_q   <= 1'b1;
					ent_q   <= 64'd0;
					len_q   <= 5'd0;
					neg_q   <= 1'b0;
					total_q <= 64'd0;
					pend_q  <= 1'b0;
					start_q <= 1'b1;
				end
				CMD_SHOW_DONE: begin
					if (too_long) begin
						err_q <= 1'b1;
						ent_q <= 64'd0;
						len_q <= 5'd0;
						neg_q <= 1'b0;
					end else begin
						ent_q <= bcd_q[63:0];
						len_q <= n_digits;
						neg_q <= vneg_q;
					end
				end
				CMD_OP_KEY: begin
					if (!err_q) begin
						op_q    <= cmd.op;
						pend_q  <= 1'b1;
						start_q <= 1'b1;
					end
				end
				CMD_EQ_END: begin
					op_q    <= OP_ADD;
					pend_q  <= 1'b0;
					start_q <= 1'b1;
				end
				CMD_PCT_END: start_q <= 1'b0;
				CMD_MR_END:  start_q <= 1'b1;
				CMD_MEM_STORE: begin
					mem_q  <= x_q;
					memv_q <= 1'b1;
				end
				CMD_MEM_ADD: begin
					mem_q  <= mem_q + x_q;
					memv_q <= 1'b1;
				end
				CMD_MEM_SUB: begin
					mem_q  <= mem_q - x_q;
					memv_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_PARSE_INIT: begin
				x_q   <= 64'd0;
				y_q   <= ent_q;
				cnt_q <= 6'd0;
			end
			CMD_PARSE_STEP: begin
				// Digits above the entry length are zero, so all sixteen are folded in.
				x_q   <= (x_q << 3) + (x_q << 1) + {60'd0, y_q[63:60]};
				y_q   <= y_q << 4;
				cnt_q <= cnt_q + 6'd1;
			end
			CMD_PARSE_FIX: begin
				if (neg_q)
					x_q <= 64'd0 - x_q;
			end
			CMD_SET_R_X:  r_q <= x_q;
			CMD_ALU:      r_q <= (op_q == OP_SUB) ? total_q - x_q : total_q + x_q;
			CMD_NEG_X:    r_q <= 64'd0 - x_q;
			CMD_LOAD_MEM: r_q <= mem_q;
			CMD_MUL_INIT: begin
				a_q   <= total_q;
				b_q   <= x_q;
				r_q   <= 64'd0;
				cnt_q <= 6'd0;
			end
			CMD_MUL_STEP: begin
				if (b_q[0])
					r_q <= r_q + a_q;
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + 6'd1;
			end
			CMD_DIV_INIT: begin
				a_q    <= dvd[63] ? 64'd0 - dvd : dvd;
				b_q    <= dvs[63] ? 64'd0 - dvs : dvs;
				qneg_q <= dvd[63] ^ dvs[63];
				rem_q  <= 65'd0;
				cnt_q  <= 6'd0;
			end
			CMD_DIV_STEP: begin
				rem_q <= rem_ge ? rem_sh - {1'b0, b_q} : rem_sh;
				a_q   <= {a_q[62:0], rem_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			CMD_DIV_FIX: r_q <= qneg_q ? 64'd0 - a_q : a_q;
			CMD_SHOW_INIT: begin
				a_q    <= r_q[63] ? 64'd0 - r_q : r_q;
				vneg_q <= r_q[63];
				bcd_q  <= '0;
				cnt_q  <= 6'd0;
			end
			CMD_SHOW_STEP: begin
				bcd_q <= {adj[BCD_W-2:0], a_q[63]};
				a_q   <= a_q << 1;
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	assign status.step_last  = (cnt_q == 6'(WORD_STEPS - 1));
	assign status.parse_last = (cnt_q == 6'(MAX_DIGITS - 1));
	assign status.x_zero     = (x_q == 64'd0);
	assign status.pend       = pend_q;
	assign status.op         = op_q;
	assign status.err        = err_q;
	assign status.memv       = memv_q;

	assign view.key_accepted     = 1'b0;
	assign view.shown_digits     = err_q ? 64'd0 : ent_q;
	assign view.shown_length     = err_q ? 5'd0 : len_q;
	assign view.shown_negative   = !err_q && neg_q;
	assign view.error_shown      = err_q;
	assign view.memory_indicator = memv_q && (mem_q != 64'd0);

	assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> (len_q == 5'd0 && !neg_q && ent_q == 64'd0))
		else $error("error latched with a live entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= 5'(MAX_DIGITS) && (ent_q >> {len_q, 2'b00}) == 64'd0)
		else $error("entry holds digits above its length");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!pend_q && !err_q) |-> op_q == OP_ADD)
		else $error("operator left set with nothing pending");

endmodule

@@ hw/rtl/keypad_integer_calculator.sv @@
// Keypad integer calculator: one ASCII key word in, one display word out.
// Channel keys carries key_code; channel display carries the display state after the key.
// Keys that need no arithmetic (digits, clear, backspace, memory clear, unknown codes,
// any key while ERR shows) go straight from dispatch to the result.
// Keys that read the entry take a decimal parse; a result to be shown adds a binary to
// BCD conversion; a product or a quotient adds a pass each through the shift-add
// multiplier or the restoring divider. The worst case is percent with an operator pending.
// One key is processed at a time: keys.ready is high only while the controller idles.
// The result sits in an output register; the next key is taken while it waits, and a
// later result waits in the controller until the receiver has taken the earlier one.
// Reset clears the entry to a single zero, the total, the operator, the error and the
// memory, and leaves no result pending.
// Depends on kic_pkg, kic_stream_if, kic_ctrl and kic_dp.
module keypad_integer_calculator
	import kic_pkg::*;
#(
	parameter int DISPLAY_CHARS = 16
)
(
	input  logic          clk,
	input  logic          arst_n,
	kic_stream_if.sink    keys,
	kic_stream_if.source  display
);

	dp_cmd_t       cmd;
	dp_status_t    status;
	display_item_t view, word;
	logic          out_busy, out_load, acc;
	logic          out_valid_q;
	display_item_t out_data_q;

	assign out_busy = out_valid_q && !display.ready;

	kic_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (keys.valid),
		.key_code     (keys.data.key_code),
		.in_ready     (keys.ready),
		.out_busy     (out_busy),
		.out_load     (out_load),
		.key_accepted (acc),
		.cmd          (cmd),
		.status       (status)
	);

	kic_dp #(.DISPLAY_CHARS(DISPLAY_CHARS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.view   (view)
	);

	always_comb begin
		word              = view;
		word.key_accepted = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (display.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= word;
	end

	assign display.valid = out_valid_q;
	assign display.data  = out_data_q;

endmodule
